/* src/bounding_volume_overlap_test_defines.svh */
// ----------------------------------------------------------------------------
// Bounding volume overlap test: assertion macros
// Concurrent check macros shared by the RTL; they expand to nothing when the
// code is built for synthesis.
// ----------------------------------------------------------------------------
`ifndef BOUNDING_VOLUME_OVERLAP_TEST_DEFINES_SVH
`define BOUNDING_VOLUME_OVERLAP_TEST_DEFINES_SVH

`ifndef SYNTHESIS
// Antecedent and consequent in the same cycle.
`define BVOT_ASSERT_IMP(lbl, clk_i, rst_n_i, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_n_i) (ante) |-> (cons)) \
		else $error("bvot: same-cycle check failed");
// Consequent in the cycle after the antecedent.
`define BVOT_ASSERT_NEXT(lbl, clk_i, rst_n_i, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_n_i) (ante) |=> (cons)) \
		else $error("bvot: next-cycle check failed");
`else
`define BVOT_ASSERT_IMP(lbl, clk_i, rst_n_i, ante, cons)
`define BVOT_ASSERT_NEXT(lbl, clk_i, rst_n_i, ante, cons)
`endif

`endif

/* src/bvot_pkg.sv */
// ----------------------------------------------------------------------------
// Bounding volume overlap test: package
// Coordinate type, beat payloads, region record, register indexes and the
// stage enables passed from the pipeline control to the datapath.
// ----------------------------------------------------------------------------
package bvot_pkg;

	localparam int COORD_WIDTH = 16;
	localparam int CFG_ADDR_W  = 3;
	localparam int CFG_DATA_W  = COORD_WIDTH;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_IS_SPHERE = 3'd0,
		REG_P_X       = 3'd1,
		REG_P_Y       = 3'd2,
		REG_P_Z       = 3'd3,
		REG_Q_X       = 3'd4,
		REG_Q_Y       = 3'd5,
		REG_Q_Z       = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic   item_is_sphere;
		coord_t item_p_x;
		coord_t item_p_y;
		coord_t item_p_z;
		coord_t item_q_x;
		coord_t item_q_y;
		coord_t item_q_z;
	} item_t;

	typedef struct packed {
		logic overlaps;
		logic encloses;
	} result_t;

	// A box holds its minimum corner in p and maximum corner in q; a sphere
	// holds its centre in p and its radius in q[0]. Index 0 is x.
	typedef struct packed {
		logic         is_sphere;
		coord_t [2:0] p;
		coord_t [2:0] q;
	} region_t;

	typedef struct packed {
		logic s2;
		logic s3;
		logic s4;
	} stage_en_t;

endpackage

/* src/bounding_volume_overlap_test.sv */
// ----------------------------------------------------------------------------
// Bounding volume overlap test
// Tests each incoming box or sphere against a reference box or sphere held in
// configuration registers and reports whether the two overlap and whether the
// reference fully encloses the item. One beat is accepted every clock cycle
// when the output side keeps up; each beat passes in order through the four
// register stages (input register, differences, squares, result register),
// the first of which is loaded by the accepting edge. Stall on the input
// rises only when all four stages are full and the output is stalled.
// Configuration registers should be written only while no beat is in flight.
// ----------------------------------------------------------------------------
`include "bounding_volume_overlap_test_defines.svh"

module bounding_volume_overlap_test
	import bvot_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  item_t                 in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output result_t               out_data
);

	region_t   ref_rgn_q;
	region_t   in_rgn;
	region_t   item_s1;
	logic      valid_s1, valid_s2, valid_s3, valid_s4;
	logic      take1, take2, take3, take4;
	logic      tail_blocked;
	stage_en_t stage_en;
	result_t   dp_result;

	// Reference region registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_rgn_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_reg_t'(cfg_addr))
				REG_IS_SPHERE: ref_rgn_q.is_sphere <= cfg_wdata[0];
				REG_P_X:       ref_rgn_q.p[0]      <= coord_t'(cfg_wdata);
				REG_P_Y:       ref_rgn_q.p[1]      <= coord_t'(cfg_wdata);
				REG_P_Z:       ref_rgn_q.p[2]      <= coord_t'(cfg_wdata);
				REG_Q_X:       ref_rgn_q.q[0]      <= coord_t'(cfg_wdata);
				REG_Q_Y:       ref_rgn_q.q[1]      <= coord_t'(cfg_wdata);
				REG_Q_Z:       ref_rgn_q.q[2]      <= coord_t'(cfg_wdata);
				default:       ;
			endcase
		end
	end

	always_comb begin
		in_rgn.is_sphere = in_data.item_is_sphere;
		in_rgn.p[0]      = in_data.item_p_x;
		in_rgn.p[1]      = in_data.item_p_y;
		in_rgn.p[2]      = in_data.item_p_z;
		in_rgn.q[0]      = in_data.item_q_x;
		in_rgn.q[1]      = in_data.item_q_y;
		in_rgn.q[2]      = in_data.item_q_z;
	end

	// A stage takes a new beat when it is empty or its contents move on.
	assign take4 = !valid_s4 || !out_stall;
	assign take3 = !valid_s3 || take4;
	assign take2 = !valid_s2 || take3;
	assign take1 = !valid_s1 || take2;

	assign in_stall    = !take1;
	assign stage_en.s2 = take2 && valid_s1;
	assign stage_en.s3 = take3 && valid_s2;
	assign stage_en.s4 = take4 && valid_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (take1)
				valid_s1 <= in_valid;
			if (take2)
				valid_s2 <= valid_s1;
			if (take3)
				valid_s3 <= valid_s2;
			if (take4)
				valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (take1 && in_valid)
			item_s1 <= in_rgn;
	end

	bvot_datapath u_datapath (
		.clk      (clk),
		.ref_rgn  (ref_rgn_q),
		.item_rgn (item_s1),
		.en       (stage_en),
		.result   (dp_result)
	);

	assign out_valid = valid_s4;
	assign out_data  = dp_result;

	assign tail_blocked = valid_s2 && valid_s3 && valid_s4 && out_stall;

	`BVOT_ASSERT_NEXT(a_accept_fills_s1, clk, arst_n, in_valid && !in_stall, valid_s1)
	`BVOT_ASSERT_NEXT(a_s2_held_when_blocked, clk, arst_n, tail_blocked, valid_s2)
	`BVOT_ASSERT_IMP(a_full_pipe_stalls, clk, arst_n, valid_s1 && tail_blocked, in_stall)

endmodule

/* src/bvot_datapath.sv */
// ----------------------------------------------------------------------------
// Bounding volume overlap test: datapath
// Three register stages after the input register: differences and box
// compares, exact squares, then sums of squares and the final selection.
// ----------------------------------------------------------------------------
module bvot_datapath
	import bvot_pkg::*;
(
	input  logic      clk,
	input  region_t   ref_rgn,
	input  region_t   item_rgn,
	input  stage_en_t en,
	output result_t   result
);

	localparam int DIFF_W = COORD_WIDTH + 1;
	localparam int BOX_W  = COORD_WIDTH + 3;
	localparam int ROOT_W = COORD_WIDTH;
	localparam int SQ_W   = 2 * DIFF_W;
	localparam int LIM_W  = 2 * ROOT_W;
	localparam int SSQ_W  = SQ_W + 2;

	typedef logic signed [DIFF_W-1:0] diff_t;
	typedef logic signed [BOX_W-1:0]  box_t;
	typedef logic [SQ_W-1:0]          sq_t;
	typedef logic [ROOT_W-1:0]        root_t;
	typedef logic [LIM_W-1:0]         lim_t;
	typedef logic [SSQ_W-1:0]         ssq_t;

	typedef struct packed {
		logic ref_sph;
		logic item_sph;
		logic bb_ovl;
		logic pin_p;
		logic pin_q;
		logic face_ok;
		logic dr_pos;
	} flags_t;

	function automatic diff_t dx(input coord_t a, input coord_t b);
		return DIFF_W'(a) - DIFF_W'(b);
	endfunction

	function automatic logic [DIFF_W-1:0] mag(input diff_t v);
		return v[DIFF_W-1] ? $unsigned(-v) : $unsigned(v);
	endfunction

	function automatic box_t bx(input coord_t a);
		return BOX_W'(a);
	endfunction

	// ---------------- stage 2: differences and compares ----------------
	root_t        ref_rad, item_rad;
	root_t        ovl_root_d, enc_root_d;
	flags_t       flags_d;
	diff_t [2:0]  v1_d, v2_d, v3_d;
	coord_t       rp, rq, ip, iq, sc, bmin, bmax, cp;
	box_t         csum, span;

	assign ref_rad  = ref_rgn.q[0][COORD_WIDTH-1] ? '0 : ROOT_W'($unsigned(ref_rgn.q[0]));
	assign item_rad = item_rgn.q[0][COORD_WIDTH-1] ? '0 : ROOT_W'($unsigned(item_rgn.q[0]));

	always_comb begin
		flags_d.ref_sph  = ref_rgn.is_sphere;
		flags_d.item_sph = item_rgn.is_sphere;
		flags_d.bb_ovl   = 1'b1;
		flags_d.pin_p    = 1'b1;
		flags_d.pin_q    = 1'b1;
		flags_d.face_ok  = 1'b1;
		flags_d.dr_pos   = ref_rad > item_rad;
		rp = '0; rq = '0; ip = '0; iq = '0;
		sc = '0; bmin = '0; bmax = '0; cp = '0;
		csum = '0; span = '0;
		for (int i = 0; i < 3; i++) begin
			rp = ref_rgn.p[i];
			rq = ref_rgn.q[i];
			ip = item_rgn.p[i];
			iq = item_rgn.q[i];
			// Doubled centre offset against the sum of the two extents.
			csum = (bx(rp) + bx(rq)) - (bx(ip) + bx(iq));
			span = (bx(rq) - bx(rp)) + (bx(iq) - bx(ip));
			if (csum > span || -csum > span)
				flags_d.bb_ovl = 1'b0;
			if (ip < rp || ip > rq)
				flags_d.pin_p = 1'b0;
			if (iq < rp || iq > rq)
				flags_d.pin_q = 1'b0;
			if (mag(dx(rq, ip)) < DIFF_W'(item_rad) || mag(dx(ip, rp)) < DIFF_W'(item_rad))
				flags_d.face_ok = 1'b0;
			v1_d[i] = dx(rp, ip);
			v2_d[i] = dx(iq, rp);
			// Clamp the sphere centre into the box; the offset is the gap.
			sc   = ref_rgn.is_sphere ? rp : ip;
			bmin = ref_rgn.is_sphere ? ip : rp;
			bmax = ref_rgn.is_sphere ? iq : rq;
			cp   = (sc < bmax) ? sc : bmax;
			if (cp < bmin)
				cp = bmin;
			v3_d[i] = dx(cp, sc);
		end
	end

	always_comb begin
		if (ref_rgn.is_sphere && item_rgn.is_sphere)
			ovl_root_d = ref_rad + item_rad;
		else if (ref_rgn.is_sphere)
			ovl_root_d = ref_rad;
		else
			ovl_root_d = item_rad;
		enc_root_d = item_rgn.is_sphere ? ref_rad - item_rad : ref_rad;
	end

	flags_t      flags_s2;
	diff_t [2:0] v1_s2, v2_s2, v3_s2;
	root_t       ovl_root_s2, enc_root_s2;

	always_ff @(posedge clk) begin
		if (en.s2) begin
			flags_s2    <= flags_d;
			v1_s2       <= v1_d;
			v2_s2       <= v2_d;
			v3_s2       <= v3_d;
			ovl_root_s2 <= ovl_root_d;
			enc_root_s2 <= enc_root_d;
		end
	end

	// ---------------- stage 3: exact squares ----------------
	sq_t [2:0]                sq1_d, sq2_d, sq3_d;
	logic signed [SQ_W-1:0]   prod1, prod2, prod3;
	lim_t                     ovl_lim_d, enc_lim_d;

	always_comb begin
		prod1 = '0;
		prod2 = '0;
		prod3 = '0;
		for (int i = 0; i < 3; i++) begin
			prod1    = SQ_W'(v1_s2[i]) * SQ_W'(v1_s2[i]);
			prod2    = SQ_W'(v2_s2[i]) * SQ_W'(v2_s2[i]);
			prod3    = SQ_W'(v3_s2[i]) * SQ_W'(v3_s2[i]);
			sq1_d[i] = $unsigned(prod1);
			sq2_d[i] = $unsigned(prod2);
			sq3_d[i] = $unsigned(prod3);
		end
		ovl_lim_d = LIM_W'(ovl_root_s2) * LIM_W'(ovl_root_s2);
		enc_lim_d = LIM_W'(enc_root_s2) * LIM_W'(enc_root_s2);
	end

	flags_t    flags_s3;
	sq_t [2:0] sq1_s3, sq2_s3, sq3_s3;
	lim_t      ovl_lim_s3, enc_lim_s3;

	always_ff @(posedge clk) begin
		if (en.s3) begin
			flags_s3   <= flags_s2;
			sq1_s3     <= sq1_d;
			sq2_s3     <= sq2_d;
			sq3_s3     <= sq3_d;
			ovl_lim_s3 <= ovl_lim_d;
			enc_lim_s3 <= enc_lim_d;
		end
	end

	// ---------------- stage 4: sums and selection ----------------
	ssq_t    ssq1, ssq2, ssq3, ovl_lim, enc_lim;
	result_t res_d, res_s4;

	assign ssq1 = SSQ_W'(sq1_s3[0]) + SSQ_W'(sq1_s3[1]) + SSQ_W'(sq1_s3[2]);
	assign ssq2 = SSQ_W'(sq2_s3[0]) + SSQ_W'(sq2_s3[1]) + SSQ_W'(sq2_s3[2]);
	assign ssq3 = SSQ_W'(sq3_s3[0]) + SSQ_W'(sq3_s3[1]) + SSQ_W'(sq3_s3[2]);
	assign ovl_lim = SSQ_W'(ovl_lim_s3);
	assign enc_lim = SSQ_W'(enc_lim_s3);

	always_comb begin
		if (!flags_s3.ref_sph && !flags_s3.item_sph)
			res_d.overlaps = flags_s3.bb_ovl;
		else if (flags_s3.ref_sph && flags_s3.item_sph)
			res_d.overlaps = ssq1 < ovl_lim;
		else
			res_d.overlaps = ssq3 < ovl_lim;

		if (!flags_s3.item_sph) begin
			// Both corners of the item must lie in the reference.
			if (flags_s3.ref_sph)
				res_d.encloses = (ssq1 <= enc_lim) && (ssq2 <= enc_lim);
			else
				res_d.encloses = flags_s3.pin_p && flags_s3.pin_q;
		end else begin
			if (flags_s3.ref_sph)
				res_d.encloses = flags_s3.dr_pos && (ssq1 < enc_lim);
			else
				res_d.encloses = flags_s3.pin_p && flags_s3.face_ok;
		end
	end

	always_ff @(posedge clk) begin
		if (en.s4)
			res_s4 <= res_d;
	end

	assign result = res_s4;

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounding volume overlap test: testbench
// Streams boxes, points and spheres against a series of reference regions and
// checks every overlap and enclosure verdict against an in-bench predictor.
// The input side idles and the output side stalls at random in several phases,
// including a long output hold-off that backs the pipeline up to its input.
// ----------------------------------------------------------------------------
module testbench;
	import bvot_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int LONG_HOLD   = 150;
	localparam int SETTLE      = 8;
	localparam int PHASE_BEATS = 130;
	localparam logic [CFG_ADDR_W-1:0] REG_UNMAPPED = 3'd7;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_wr_en = 1'b0;
	logic [CFG_ADDR_W-1:0] cfg_addr = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	item_t                 in_data = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	result_t               out_data;

	item_t   regions_to_send[$];
	result_t verdicts_due[$];
	result_t want_verdict;
	region_t ref_region = '0;

	int  send_idle_pct = 0;
	int  recv_stall_pct = 0;
	bit  hold_armed = 1'b0;
	int  hold_cycles = 0;
	int  cycle_count = 0;
	int  faults = 0;
	int  beats_sent = 0;
	int  beats_checked = 0;
	int  overlap_hits = 0;
	int  enclose_hits = 0;
	int  input_stall_cycles = 0;
	int  reference_settings = 0;

	bounding_volume_overlap_test u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------
	function automatic longint wide(coord_t v);
		return v;
	endfunction

	function automatic longint mag(longint v);
		return (v < 0) ? -v : v;
	endfunction

	function automatic logic point_inside(logic sph, longint lo[3], longint hi[3],
			longint rad, longint pt[3]);
		longint ssq;
		ssq = 0;
		if (!sph) begin
			for (int i = 0; i < 3; i++)
				if (pt[i] < lo[i] || pt[i] > hi[i])
					return 1'b0;
			return 1'b1;
		end
		for (int i = 0; i < 3; i++)
			ssq += (pt[i] - lo[i]) * (pt[i] - lo[i]);
		return ssq <= rad * rad;
	endfunction

	function automatic result_t region_verdict(region_t a, item_t it);
		longint ap[3], aq[3], bp[3], bq[3];
		longint ra, rb, rs, ssq, lhs, rhs, c, lo, hi, cp, dr;
		logic bs;
		result_t v;
		bs = it.item_is_sphere;
		bp[0] = wide(it.item_p_x);
		bp[1] = wide(it.item_p_y);
		bp[2] = wide(it.item_p_z);
		bq[0] = wide(it.item_q_x);
		bq[1] = wide(it.item_q_y);
		bq[2] = wide(it.item_q_z);
		for (int i = 0; i < 3; i++) begin
			ap[i] = wide(a.p[i]);
			aq[i] = wide(a.q[i]);
		end
		// A negative radius counts as zero.
		ra = (aq[0] < 0) ? 0 : aq[0];
		rb = (bq[0] < 0) ? 0 : bq[0];

		ssq = 0;
		if (!a.is_sphere && !bs) begin
			// Doubled centres against summed extents; touching boxes overlap.
			v.overlaps = 1'b1;
			for (int i = 0; i < 3; i++) begin
				lhs = mag((ap[i] + aq[i]) - (bp[i] + bq[i]));
				rhs = (aq[i] - ap[i]) + (bq[i] - bp[i]);
				if (rhs < 0 || lhs > rhs)
					v.overlaps = 1'b0;
			end
		end else if (a.is_sphere && bs) begin
			for (int i = 0; i < 3; i++)
				ssq += (ap[i] - bp[i]) * (ap[i] - bp[i]);
			v.overlaps = ssq < (ra + rb) * (ra + rb);
		end else begin
			// Clamp the sphere centre into the box, then measure to it.
			rs = a.is_sphere ? ra : rb;
			for (int i = 0; i < 3; i++) begin
				c  = a.is_sphere ? ap[i] : bp[i];
				lo = a.is_sphere ? bp[i] : ap[i];
				hi = a.is_sphere ? bq[i] : aq[i];
				cp = (c < hi) ? c : hi;
				if (cp < lo)
					cp = lo;
				ssq += (cp - c) * (cp - c);
			end
			v.overlaps = ssq < rs * rs;
		end

		if (!bs) begin
			v.encloses = point_inside(a.is_sphere, ap, aq, ra, bp) &&
				point_inside(a.is_sphere, ap, aq, ra, bq);
		end else if (a.is_sphere) begin
			dr = ra - rb;
			ssq = 0;
			for (int i = 0; i < 3; i++)
				ssq += (ap[i] - bp[i]) * (ap[i] - bp[i]);
			v.encloses = (dr > 0) && (ssq < dr * dr);
		end else begin
			v.encloses = point_inside(1'b0, ap, aq, ra, bp);
			for (int i = 0; i < 3; i++)
				if (mag(aq[i] - bp[i]) < rb || mag(bp[i] - ap[i]) < rb)
					v.encloses = 1'b0;
		end
		return v;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	function automatic coord_t pick_extreme();
		case ($urandom_range(4))
			0: return coord_t'(-32768);
			1: return coord_t'(-1);
			2: return coord_t'(0);
			3: return coord_t'(1);
			default: return coord_t'(32767);
		endcase
	endfunction

	function automatic coord_t pick_coord(coord_t base, int spread);
		case ($urandom_range(9))
			0: return coord_t'($urandom);
			1: return pick_extreme();
			default: return coord_t'(int'(base) + int'($urandom_range(2 * spread)) - spread);
		endcase
	endfunction

	function automatic coord_t stretch(coord_t lo, int spread);
		case ($urandom_range(9))
			0: return coord_t'($urandom);
			1: return coord_t'(int'(lo) - int'($urandom_range(spread)));
			default: return coord_t'(int'(lo) + int'($urandom_range(spread)));
		endcase
	endfunction

	function automatic item_t random_region(int spread);
		item_t it;
		it.item_is_sphere = 1'($urandom_range(1));
		it.item_p_x = pick_coord(ref_region.p[0], spread);
		it.item_p_y = pick_coord(ref_region.p[1], spread);
		it.item_p_z = pick_coord(ref_region.p[2], spread);
		if (it.item_is_sphere) begin
			case ($urandom_range(9))
				0: it.item_q_x = coord_t'(-int'($urandom_range(1, 32768)));
				1: it.item_q_x = pick_extreme();
				default: it.item_q_x = coord_t'($urandom_range(spread));
			endcase
			it.item_q_y = coord_t'($urandom);
			it.item_q_z = coord_t'($urandom);
		end else begin
			it.item_q_x = stretch(it.item_p_x, spread);
			it.item_q_y = stretch(it.item_p_y, spread);
			it.item_q_z = stretch(it.item_p_z, spread);
		end
		return it;
	endfunction

	task automatic push_region(input logic sph, input int px, py, pz, qx, qy, qz);
		item_t it;
		it.item_is_sphere = sph;
		it.item_p_x = coord_t'(px);
		it.item_p_y = coord_t'(py);
		it.item_p_z = coord_t'(pz);
		it.item_q_x = coord_t'(qx);
		it.item_q_y = coord_t'(qy);
		it.item_q_z = coord_t'(qz);
		regions_to_send.push_back(it);
	endtask

	task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= val;
		case (idx)
			REG_IS_SPHERE: ref_region.is_sphere = val[0];
			REG_P_X: ref_region.p[0] = val;
			REG_P_Y: ref_region.p[1] = val;
			REG_P_Z: ref_region.p[2] = val;
			REG_Q_X: ref_region.q[0] = val;
			REG_Q_Y: ref_region.q[1] = val;
			REG_Q_Z: ref_region.q[2] = val;
			default: ;
		endcase
	endtask

	task automatic set_reference(input logic sph, input int px, py, pz, qx, qy, qz);
		write_reg(REG_IS_SPHERE, {{(CFG_DATA_W-1){1'b0}}, sph});
		write_reg(REG_P_X, CFG_DATA_W'(px));
		write_reg(REG_P_Y, CFG_DATA_W'(py));
		write_reg(REG_P_Z, CFG_DATA_W'(pz));
		write_reg(REG_Q_X, CFG_DATA_W'(qx));
		write_reg(REG_Q_Y, CFG_DATA_W'(qy));
		write_reg(REG_Q_Z, CFG_DATA_W'(qz));
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(negedge clk);
		reference_settings++;
	endtask

	// Waits until every queued beat has gone in and every verdict come out,
	// then lets the pipeline settle before anything is reconfigured.
	task automatic wait_quiet();
		do
			@(negedge clk);
		while (regions_to_send.size() != 0 || in_valid || verdicts_due.size() != 0);
		hold_armed = 1'b0;
		repeat (SETTLE) @(posedge clk);
		@(negedge clk);
	endtask

	// ------------------------------------------------------------------
	// Driver
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data  <= '0;
		end else begin
			if (in_valid && !in_stall) begin
				verdicts_due.push_back(region_verdict(ref_region, in_data));
				beats_sent++;
			end
			if (in_valid && in_stall)
				input_stall_cycles++;
			if (!in_valid || !in_stall) begin
				if (regions_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					in_data  <= regions_to_send.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// The long hold-off is timed here, apart from the random stalls.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			hold_cycles <= 0;
		else if (!hold_armed)
			hold_cycles <= 0;
		else if (hold_cycles != LONG_HOLD)
			hold_cycles <= hold_cycles + 1;
	end

	// ------------------------------------------------------------------
	// Monitor
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (verdicts_due.size() == 0) begin
					faults++;
					if (faults <= 10)
						$display("Unexpected result beat: overlaps=%0b encloses=%0b",
							out_data.overlaps, out_data.encloses);
				end else begin
					want_verdict = verdicts_due.pop_front();
					if (want_verdict.overlaps) overlap_hits++;
					if (want_verdict.encloses) enclose_hits++;
					if (out_data.overlaps !== want_verdict.overlaps ||
							out_data.encloses !== want_verdict.encloses) begin
						faults++;
						if (faults <= 10)
							$display("Mismatch at result %0d: ", beats_checked,
								"expected overlaps=%0b encloses=%0b, ",
								want_verdict.overlaps, want_verdict.encloses,
								"got overlaps=%0b encloses=%0b",
								out_data.overlaps, out_data.encloses);
					end
				end
				beats_checked++;
			end
			out_stall <= (hold_armed && hold_cycles != LONG_HOLD) ||
				($urandom_range(99) < recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d verdicts outstanding.",
				cycle_count, verdicts_due.size());
			$display("bounding_volume_overlap_test verification failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------
	initial begin
		int spread;
		int mode;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// The reference out of reset is a box shrunk to the origin.
		push_region(1'b0, 0, 0, 0, 0, 0, 0);
		push_region(1'b0, -1, -1, -1, 1, 1, 1);
		push_region(1'b1, 0, 0, 0, 0, 0, 0);
		wait_quiet();

		// Box reference; an unmapped register index must change nothing.
		write_reg(REG_UNMAPPED, 16'hbeef);
		set_reference(1'b0, -100, -100, -100, 100, 100, 100);
		push_region(1'b0, -10, -10, -10, 10, 10, 10);
		push_region(1'b0, 100, 0, 0, 200, 10, 10);
		push_region(1'b0, 101, 0, 0, 200, 10, 10);
		push_region(1'b0, 100, -100, 100, 100, -100, 100);
		push_region(1'b0, -32768, -32768, -32768, 32767, 32767, 32767);
		push_region(1'b0, 50, 50, 50, -50, -50, -50);
		push_region(1'b1, 0, 0, 0, 50, 32767, -32768);
		push_region(1'b1, 0, 0, 0, 100, 0, 0);
		push_region(1'b1, 0, 0, 0, 101, 0, 0);
		push_region(1'b1, 90, 0, 0, -5, 0, 0);
		push_region(1'b1, 110, 110, 110, 18, 0, 0);
		push_region(1'b1, 110, 110, 110, 17, 0, 0);
		wait_quiet();

		// Sphere reference with junk in the unused fields.
		set_reference(1'b1, 0, 0, 0, 1000, -1, 12345);
		push_region(1'b0, -500, -500, -500, 500, 500, 500);
		push_region(1'b0, -600, -600, -600, 600, 600, 600);
		push_region(1'b0, 1000, 0, 0, 1000, 0, 0);
		push_region(1'b1, 1500, 0, 0, 500, 0, 0);
		push_region(1'b1, 1499, 0, 0, 500, 0, 0);
		push_region(1'b1, 100, 0, 0, 800, 0, 0);
		push_region(1'b1, 0, 0, 0, 1000, 0, 0);
		wait_quiet();

		set_reference(1'b1, -32768, -32768, -32768, 32767, 32767, 32767);
		push_region(1'b1, 32767, 32767, 32767, 32767, 0, 0);
		push_region(1'b0, -32768, -32768, -32768, 32767, 32767, 32767);
		wait_quiet();

		set_reference(1'b0, -32768, -32768, -32768, 32767, 32767, 32767);
		push_region(1'b1, 0, 0, 0, -32768, 0, 0);
		push_region(1'b1, 32767, 32767, 32767, 32767, 0, 0);
		wait_quiet();

		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: begin
					set_reference(1'b0, -50, -20, 0, 50, 80, 40);
					spread = 120;
				end
				1: begin
					set_reference(1'b1, 100, -100, 30, 150, $urandom, $urandom);
					spread = 250;
				end
				2: begin
					set_reference(1'b0, -32768, -32768, -32768, 32767, 32767, 32767);
					spread = 32767;
				end
				3: begin
					set_reference(1'b1, $urandom, $urandom, $urandom, 32767, $urandom, $urandom);
					spread = 20000;
				end
				4: begin
					// Inverted reference box: minimum above maximum.
					set_reference(1'b0, 60, 40, 20, -60, -40, -20);
					spread = 150;
				end
				5: begin
					set_reference(1'b1, $urandom_range(400), $urandom_range(400), 0,
						-int'($urandom_range(1, 32768)), $urandom, $urandom);
					spread = 200;
				end
				6: begin
					set_reference(1'b0, $urandom, $urandom, $urandom,
						$urandom, $urandom, $urandom);
					spread = 32767;
				end
				default: begin
					set_reference(1'b1, $urandom, $urandom, $urandom,
						$urandom_range(2000), $urandom, $urandom);
					spread = 2500;
				end
			endcase
			mode = ph % 4;
			send_idle_pct  = (mode == 1) ? 61 : (mode == 3) ? 16 : 0;
			recv_stall_pct = (mode == 2) ? 61 : (mode == 3) ? 16 : 0;
			hold_armed = (ph == 0 || ph == 5);
			for (int n = 0; n < PHASE_BEATS; n++)
				regions_to_send.push_back(random_region(spread));
			wait_quiet();
		end

		faults += verdicts_due.size();
		$display("Checked %0d of %0d region beats against %0d reference settings.",
			beats_checked, beats_sent, reference_settings);
		$display("Verdicts: %0d overlapping, %0d enclosed; ", overlap_hits, enclose_hits,
			"input held by back-pressure for %0d cycles.", input_stall_cycles);
		if (faults == 0)
			$display("bounding_volume_overlap_test verification clean");
		else
			$display("bounding_volume_overlap_test verification failed");
		$finish;
	end

endmodule
